// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Invariant checked on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("invariant check failed");

`endif

// ----- rtl/core/stb_pkg.sv -----
// Package with op codes and sequencer states for the timer bank.
package stb_pkg;

    typedef enum logic [2:0] {
        OP_SET     = 3'd0,
        OP_RESET   = 3'd1,
        OP_RESTART = 3'd2,
        OP_QUERY   = 3'd3,
        OP_REMAIN  = 3'd4,
        OP_REMOVE  = 3'd5,
        OP_SCAN    = 3'd6
    } t_op;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_FIND = 6'b000010,
        S_RD   = 6'b000100,
        S_CALC = 6'b001000,
        S_ADJ  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

endpackage

// ----- rtl/core/software_timer_bank.sv -----
// Interval timer bank: per-slot state memory, flag vectors and a shared add/compare unit.
//
// Input channel: i_valid/o_stall carry one command item (op, timer id, interval,
// current time). Output channel: o_valid/i_stall carry one result item per command.
// One command is worked on at a time; o_stall stays high from acceptance until the
// result has been taken. States passed from acceptance to o_valid:
//   remove, invalid id, unused op: straight to the output
//   set with explicit id, restart, query: read, then calc
//   reset, remaining: read, calc, then adjust if needed (one extra pass through the adder)
//   set with id 0: free search, one slot of the search per cycle, then read and calc
//   scan: read, then elapsed compare and write, per slot from 1 to NUM_TIMERS-1
// The sequence is set by the slot memory with its one read port and the one shared adder.
// The next item can be taken in the cycle after the result is accepted.
// A stalled result is held in its output registers until i_stall drops.
// Synchronous reset clears all slot flags and per-slot written bits; slots that
// were never written read as zero, so no clearing pass is needed.
`include "assert_macros.svh"

module software_timer_bank #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [3:0]  i_timer_sel,
    input  logic [31:0] i_new_interval,
    input  logic [31:0] i_now_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_granted_id,
    output logic        o_is_expired,
    output logic [31:0] o_time_left
);

    localparam int             IW        = (NUM_TIMERS > 2) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [31:0]    NUM_W     = 32'(NUM_TIMERS);
    localparam logic [IW-1:0]  FIRST_IDX = IW'(1);
    localparam logic [IW-1:0]  LAST_IDX  = IW'(NUM_TIMERS - 1);

    typedef struct packed {
        logic [TIME_BITS-1:0] start_time;
        logic [TIME_BITS-1:0] period;
        logic [TIME_BITS-1:0] last_elapsed;
    } t_entry;

    stb_pkg::t_state r_state, n_state;
    stb_pkg::t_op    r_op, n_op;
    logic [IW-1:0]        r_idx, n_idx;
    logic [TIME_BITS-1:0] r_ival, n_ival;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [TIME_BITS-1:0] r_el, n_el;
    logic [3:0]           r_granted, n_granted;
    logic                 r_expd, n_expd;
    logic [31:0]          r_left, n_left;

    logic [NUM_TIMERS-1:0] r_in_use, n_in_use;
    logic [NUM_TIMERS-1:0] r_running, n_running;
    logic [NUM_TIMERS-1:0] r_expired, n_expired;
    logic [NUM_TIMERS-1:0] r_ok;

    t_entry r_mem [NUM_TIMERS];
    t_entry r_rd;
    logic   r_rd_ok;

    t_entry               w_ent;
    t_entry               w_wdata;
    logic                 w_we;
    logic [TIME_BITS-1:0] w_a, w_b, w_sum;
    logic                 w_sub;
    logic                 w_cmp;
    logic                 w_chk;
    logic                 w_sel_lt;
    logic                 w_sel_ok;

    assign w_ent    = r_rd_ok ? r_rd : '0;
    assign w_sum    = w_a + (w_sub ? ~w_b : w_b) + TIME_BITS'(w_sub);
    assign w_cmp    = (w_sum >= w_ent.period) || (w_sum < w_ent.last_elapsed);
    assign w_chk    = r_expired[r_idx] || w_cmp;
    assign w_sel_lt = 32'(i_timer_sel) < NUM_W;
    assign w_sel_ok = (i_timer_sel != 4'd0) && w_sel_lt;

    assign o_stall      = (r_state != stb_pkg::S_IDLE);
    assign o_valid      = (r_state == stb_pkg::S_OUT);
    assign o_granted_id = r_granted;
    assign o_is_expired = r_expd;
    assign o_time_left  = r_left;

    // adder operands: elapsed time by default, start advance or time left in S_ADJ
    always_comb begin
        w_a   = r_now;
        w_b   = w_ent.start_time;
        w_sub = 1'b1;
        if (r_state == stb_pkg::S_ADJ) begin
            if (r_op == stb_pkg::OP_RESET) begin
                w_a   = w_ent.start_time;
                w_b   = w_ent.period;
                w_sub = 1'b0;
            end else begin
                w_a   = w_ent.period;
                w_b   = r_el;
                w_sub = 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_idx     = r_idx;
        n_ival    = r_ival;
        n_now     = r_now;
        n_el      = r_el;
        n_granted = r_granted;
        n_expd    = r_expd;
        n_left    = r_left;
        n_in_use  = r_in_use;
        n_running = r_running;
        n_expired = r_expired;
        w_we      = 1'b0;
        w_wdata   = w_ent;
        case (r_state)
            stb_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_op      = stb_pkg::t_op'(i_op);
                    n_idx     = IW'(i_timer_sel);
                    n_ival    = TIME_BITS'(i_new_interval);
                    n_now     = TIME_BITS'(i_now_time);
                    n_granted = '0;
                    n_expd    = 1'b0;
                    n_left    = '0;
                    n_state   = stb_pkg::S_OUT;
                    case (stb_pkg::t_op'(i_op))
                        stb_pkg::OP_SET: begin
                            if (w_sel_lt) begin
                                if (i_timer_sel == 4'd0) begin
                                    n_idx   = FIRST_IDX;
                                    n_state = stb_pkg::S_FIND;
                                end else begin
                                    n_state = stb_pkg::S_RD;
                                end
                            end
                        end
                        stb_pkg::OP_RESET, stb_pkg::OP_RESTART, stb_pkg::OP_REMAIN: begin
                            if (w_sel_ok) begin
                                n_state = stb_pkg::S_RD;
                            end
                        end
                        stb_pkg::OP_QUERY: begin
                            if (w_sel_ok) begin
                                n_state = stb_pkg::S_RD;
                            end else begin
                                n_expd = 1'b1;
                            end
                        end
                        stb_pkg::OP_REMOVE: begin
                            if (w_sel_ok) begin
                                n_in_use[IW'(i_timer_sel)]  = 1'b0;
                                n_running[IW'(i_timer_sel)] = 1'b0;
                                n_expired[IW'(i_timer_sel)] = 1'b1;
                            end
                        end
                        stb_pkg::OP_SCAN: begin
                            n_idx   = FIRST_IDX;
                            n_state = stb_pkg::S_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            stb_pkg::S_FIND: begin
                if (!r_in_use[r_idx]) begin
                    n_in_use[r_idx] = 1'b1;
                    n_state         = stb_pkg::S_RD;
                end else if (r_idx == LAST_IDX) begin
                    n_state = stb_pkg::S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            stb_pkg::S_RD: begin
                n_state = stb_pkg::S_CALC;
            end
            stb_pkg::S_CALC: begin
                n_el    = w_sum;
                n_state = stb_pkg::S_OUT;
                case (r_op)
                    stb_pkg::OP_SET: begin
                        w_we           = 1'b1;
                        w_wdata.period = r_ival;
                        if (r_ival == '0) begin
                            n_expired[r_idx] = 1'b1;
                            n_running[r_idx] = 1'b0;
                        end else begin
                            w_wdata.start_time   = r_now;
                            w_wdata.last_elapsed = '0;
                            n_expired[r_idx]     = 1'b0;
                            n_running[r_idx]     = 1'b1;
                        end
                        n_granted = 4'(r_idx);
                    end
                    stb_pkg::OP_RESTART: begin
                        w_we                 = 1'b1;
                        w_wdata.start_time   = r_now;
                        w_wdata.last_elapsed = '0;
                        n_expired[r_idx]     = (w_ent.period == '0);
                        if (w_ent.period != '0) begin
                            n_running[r_idx] = 1'b1;
                        end
                    end
                    stb_pkg::OP_RESET, stb_pkg::OP_QUERY, stb_pkg::OP_REMAIN: begin
                        if (r_expired[r_idx]) begin
                            n_running[r_idx] = 1'b0;
                        end else if (w_cmp) begin
                            n_expired[r_idx] = 1'b1;
                            n_running[r_idx] = 1'b0;
                        end else begin
                            w_we                 = 1'b1;
                            w_wdata.last_elapsed = w_sum;
                        end
                        if (r_op == stb_pkg::OP_QUERY) begin
                            n_expd = w_chk;
                        end else if (r_op == stb_pkg::OP_RESET) begin
                            if (w_chk) begin
                                n_state = stb_pkg::S_ADJ;
                            end
                        end else if (!w_chk) begin
                            n_state = stb_pkg::S_ADJ;
                        end
                    end
                    stb_pkg::OP_SCAN: begin
                        if (r_running[r_idx]) begin
                            if (w_cmp) begin
                                n_expired[r_idx] = 1'b1;
                                n_running[r_idx] = 1'b0;
                            end else begin
                                w_we                 = 1'b1;
                                w_wdata.last_elapsed = w_sum;
                            end
                        end
                        if (r_idx != LAST_IDX) begin
                            n_idx   = r_idx + 1'b1;
                            n_state = stb_pkg::S_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            stb_pkg::S_ADJ: begin
                n_state = stb_pkg::S_OUT;
                if (r_op == stb_pkg::OP_RESET) begin
                    w_we                 = 1'b1;
                    w_wdata.start_time   = w_sum;
                    w_wdata.last_elapsed = '0;
                    n_expired[r_idx]     = (w_ent.period == '0);
                    if (w_ent.period != '0) begin
                        n_running[r_idx] = 1'b1;
                    end
                end else begin
                    n_left = 32'(w_sum);
                end
            end
            stb_pkg::S_OUT: begin
                if (!i_stall) begin
                    n_state = stb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= stb_pkg::S_IDLE;
            r_in_use  <= '0;
            r_running <= '0;
            r_expired <= '0;
            r_ok      <= '0;
        end else begin
            r_state   <= n_state;
            r_in_use  <= n_in_use;
            r_running <= n_running;
            r_expired <= n_expired;
            if (w_we) begin
                r_ok[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_idx     <= n_idx;
        r_ival    <= n_ival;
        r_now     <= n_now;
        r_el      <= n_el;
        r_granted <= n_granted;
        r_expd    <= n_expd;
        r_left    <= n_left;
    end

    // slot memory: one read and one write port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_idx] <= w_wdata;
        end
        if (r_state == stb_pkg::S_RD) begin
            r_rd    <= r_mem[r_idx];
            r_rd_ok <= r_ok[r_idx];
        end
    end

    `ASSERT_IMPLY(a_out_blocks_in, i_clk, i_rst_n, o_valid, o_stall)
    `ASSERT_ALWAYS(a_slot0_unused, i_clk, i_rst_n, !r_in_use[0] && !r_running[0])
    `ASSERT_ALWAYS(a_run_not_exp, i_clk, i_rst_n, (r_running & r_expired) == '0)
    `ASSERT_IMPLY(a_one_field, i_clk, i_rst_n, o_valid && (o_time_left != 32'd0),
                  (o_granted_id == 4'd0) && !o_is_expired)

endmodule
